// File: rtl/ehash_pkg.sv
// Shared types, defaults and state codes for the extendible hash table.
`timescale 1ns / 1ps
package ehash_pkg;

  localparam int unsigned BUCKET_SLOTS_DEF     = 8;
  localparam int unsigned MAX_GLOBAL_DEPTH_DEF = 10;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [31:0] value;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] value_out;
    logic        status;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIR,
    S_META,
    S_DECIDE,
    S_SCAN,
    S_DBL,
    S_SPLIT,
    S_REPT,
    S_MOVE,
    S_META_B,
    S_META_NB,
    S_DONE
  } st_t;

endpackage

// File: rtl/extendible_hash_table.sv
// A lookup reads directory and metadata, then scans, reading one bucket slot a cycle.
// An insert into a bucket with room writes the slot and its metadata directly; each split
// repoints the directory and moves the bucket's slots, and a doubling first copies the directory.
// The engine serves one item at a time; the input queue holds two more items.
// Reset: synchronous, active low; the table comes up empty with no clearing pass.
`timescale 1ns / 1ps
module extendible_hash_table #(
  parameter int unsigned BUCKET_SLOTS     = ehash_pkg::BUCKET_SLOTS_DEF,
  parameter int unsigned MAX_GLOBAL_DEPTH = ehash_pkg::MAX_GLOBAL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_op,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        empty,
  input  logic        pop,
  output logic        out_found,
  output logic [31:0] out_value_out,
  output logic        out_status
);
  import ehash_pkg::*;

  item_t in_item, q_item;
  res_t  res, head;
  logic  q_valid, q_pop, res_valid, res_ready;

  assign in_item.op    = op_t'(in_op);
  assign in_item.key   = in_key;
  assign in_item.value = in_value;

  ehash_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .item    (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  ehash_back #(
    .BUCKET_SLOTS     (BUCKET_SLOTS),
    .MAX_GLOBAL_DEPTH (MAX_GLOBAL_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  ehash_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign out_found     = head.found;
  assign out_value_out = head.value_out;
  assign out_status    = head.status;

endmodule

// File: rtl/ehash_front.sv
// Front end: two-entry input queue that accepts and holds items for the engine.
`timescale 1ns / 1ps
module ehash_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  ehash_pkg::item_t item,
  output logic           q_valid,
  output ehash_pkg::item_t q_item,
  input  logic           q_pop
);
  import ehash_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ do_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= item;
    end
  end

endmodule

// File: rtl/ehash_outq.sv
// Result register that presents one finished result as a queue head.
`timescale 1ns / 1ps
module ehash_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_valid,
  input  ehash_pkg::res_t res,
  output logic            res_ready,
  output logic            empty,
  input  logic            pop,
  output ehash_pkg::res_t head
);
  import ehash_pkg::*;

  logic full_r, full_nxt;
  res_t data_r;

  assign empty     = !full_r;
  assign head      = data_r;
  assign res_ready = !full_r || pop;

  always_comb begin
    full_nxt = full_r;
    if (pop && full_r) begin
      full_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

endmodule

// File: rtl/ehash_back.sv
// Back end: directory, bucket metadata and slot memories with the sequencer that serves items.
`timescale 1ns / 1ps
module ehash_back #(
  parameter int unsigned BUCKET_SLOTS     = ehash_pkg::BUCKET_SLOTS_DEF,
  parameter int unsigned MAX_GLOBAL_DEPTH = ehash_pkg::MAX_GLOBAL_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  ehash_pkg::item_t q_item,
  output logic             q_pop,
  output logic             res_valid,
  output ehash_pkg::res_t  res,
  input  logic             res_ready
);
  import ehash_pkg::*;

  localparam int unsigned DW   = MAX_GLOBAL_DEPTH;
  localparam int unsigned POOL = 1 << MAX_GLOBAL_DEPTH;
  localparam int unsigned LW   = $clog2(MAX_GLOBAL_DEPTH + 1);
  localparam int unsigned FW   = $clog2(BUCKET_SLOTS + 1);
  localparam int unsigned MW   = LW + FW;
  localparam int unsigned KW   = $clog2(POOL * BUCKET_SLOTS);

  st_t state_r, state_nxt;

  logic [DW-1:0] dir_mem [POOL];
  logic [MW-1:0] meta_mem [POOL];
  logic [31:0]   key_mem [POOL * BUCKET_SLOTS];
  logic [31:0]   val_mem [POOL * BUCKET_SLOTS];

  logic          dir_we, meta_we, kv_we;
  logic [DW-1:0] dir_waddr, dir_wdata, dir_raddr, dir_q;
  logic          dir_rd0_r;
  logic [DW-1:0] meta_waddr, meta_raddr;
  logic [MW-1:0] meta_wdata, meta_q;
  logic [KW-1:0] kv_waddr, kv_raddr;
  logic [31:0]   kv_wkey, kv_wval, kq, vq;

  logic [31:0]   key_r, key_nxt, val_r, val_nxt;
  op_t           op_r, op_nxt;
  logic [LW-1:0] gd_r, gd_nxt;
  logic [DW:0]   biu_r, biu_nxt;
  logic          b0_init_r, b0_init_nxt;
  logic [DW-1:0] b_r, b_nxt, nb_r, nb_nxt;
  logic [LW-1:0] ld_r, ld_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [DW:0]   di_r, di_nxt;
  logic [DW-1:0] pidx_r, pidx_nxt;
  logic [FW-1:0] sl_r, sl_nxt, kept_r, kept_nxt, moved_r, moved_nxt;
  logic          pend_r, pend_nxt;
  res_t          res_r, res_nxt;

  logic [DW-1:0] dir_idx, dir_data, pidx_sh;
  logic [DW:0]   dir_size;
  logic [LW-1:0] m_ld;
  logic [FW-1:0] m_fill;

  function automatic logic [KW-1:0] kv_addr(input logic [DW-1:0] b, input logic [FW-1:0] s);
    kv_addr = KW'(b) * KW'(BUCKET_SLOTS) + KW'(s);
  endfunction

  assign dir_idx   = key_r[DW-1:0] & ~({DW{1'b1}} << gd_r);
  assign dir_size  = (DW + 1)'(1) << gd_r;
  assign dir_data  = dir_rd0_r ? '0 : dir_q;
  assign pidx_sh   = pidx_r >> ld_r;
  assign res       = res_r;
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    if (b_r == '0 && !b0_init_r) begin
      m_ld   = '0;
      m_fill = '0;
    end else begin
      m_ld   = meta_q[MW-1:FW];
      m_fill = meta_q[FW-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    op_nxt      = op_r;
    gd_nxt      = gd_r;
    biu_nxt     = biu_r;
    b0_init_nxt = b0_init_r;
    b_nxt       = b_r;
    nb_nxt      = nb_r;
    ld_nxt      = ld_r;
    fill_nxt    = fill_r;
    di_nxt      = di_r;
    pidx_nxt    = pidx_r;
    sl_nxt      = sl_r;
    kept_nxt    = kept_r;
    moved_nxt   = moved_r;
    pend_nxt    = 1'b0;
    res_nxt     = res_r;
    q_pop       = 1'b0;
    dir_we      = 1'b0;
    dir_waddr   = '0;
    dir_wdata   = '0;
    dir_raddr   = '0;
    meta_we     = 1'b0;
    meta_waddr  = b_r;
    meta_wdata  = '0;
    meta_raddr  = b_r;
    kv_we       = 1'b0;
    kv_waddr    = '0;
    kv_wkey     = key_r;
    kv_wval     = val_r;
    kv_raddr    = kv_addr(b_r, sl_r);
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          op_nxt    = q_item.op;
          key_nxt   = q_item.key;
          val_nxt   = q_item.value;
          state_nxt = S_DIR;
        end
      end
      S_DIR: begin
        dir_raddr = dir_idx;
        state_nxt = S_META;
      end
      S_META: begin
        b_nxt      = dir_data;
        meta_raddr = dir_data;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        ld_nxt   = m_ld;
        fill_nxt = m_fill;
        sl_nxt   = '0;
        di_nxt   = '0;
        res_nxt  = '0;
        if (op_r == OP_LOOKUP) begin
          state_nxt = S_SCAN;
        end else if (m_fill < FW'(BUCKET_SLOTS)) begin
          kv_we      = 1'b1;
          kv_waddr   = kv_addr(b_r, m_fill);
          meta_we    = 1'b1;
          meta_wdata = {m_ld, m_fill + FW'(1)};
          if (b_r == '0) begin
            b0_init_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (m_ld >= gd_r) begin
          if (gd_r >= LW'(MAX_GLOBAL_DEPTH)) begin
            res_nxt.status = 1'b1;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_DBL;
          end
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SCAN: begin
        if (pend_r && kq == key_r) begin
          res_nxt.found     = 1'b1;
          res_nxt.value_out = vq;
          state_nxt         = S_DONE;
        end else if (sl_r < fill_r) begin
          kv_raddr = kv_addr(b_r, sl_r);
          pend_nxt = 1'b1;
          sl_nxt   = sl_r + FW'(1);
        end else if (!pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DBL: begin
        if (pend_r) begin
          dir_we    = 1'b1;
          dir_waddr = pidx_r | dir_size[DW-1:0];
          dir_wdata = dir_data;
        end
        if (di_r < dir_size) begin
          dir_raddr = di_r[DW-1:0];
          pidx_nxt  = di_r[DW-1:0];
          pend_nxt  = 1'b1;
          di_nxt    = di_r + (DW + 1)'(1);
        end else if (!pend_r) begin
          gd_nxt    = gd_r + LW'(1);
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        di_nxt = '0;
        if (biu_r >= (DW + 1)'(POOL)) begin
          res_nxt.status = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          nb_nxt    = biu_r[DW-1:0];
          biu_nxt   = biu_r + (DW + 1)'(1);
          state_nxt = S_REPT;
        end
      end
      S_REPT: begin
        if (pend_r && dir_data == b_r && pidx_sh[0]) begin
          dir_we    = 1'b1;
          dir_waddr = pidx_r;
          dir_wdata = nb_r;
        end
        if (di_r < dir_size) begin
          dir_raddr = di_r[DW-1:0];
          pidx_nxt  = di_r[DW-1:0];
          pend_nxt  = 1'b1;
          di_nxt    = di_r + (DW + 1)'(1);
        end else if (!pend_r) begin
          sl_nxt    = '0;
          kept_nxt  = '0;
          moved_nxt = '0;
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        if (pend_r) begin
          kv_we   = 1'b1;
          kv_wkey = kq;
          kv_wval = vq;
          if (kq[5'(ld_r)]) begin
            kv_waddr  = kv_addr(nb_r, moved_r);
            moved_nxt = moved_r + FW'(1);
          end else begin
            kv_waddr = kv_addr(b_r, kept_r);
            kept_nxt = kept_r + FW'(1);
          end
        end
        if (sl_r < fill_r) begin
          kv_raddr = kv_addr(b_r, sl_r);
          pend_nxt = 1'b1;
          sl_nxt   = sl_r + FW'(1);
        end else if (!pend_r) begin
          state_nxt = S_META_B;
        end
      end
      S_META_B: begin
        meta_we    = 1'b1;
        meta_waddr = b_r;
        meta_wdata = {ld_r + LW'(1), kept_r};
        if (b_r == '0) begin
          b0_init_nxt = 1'b1;
        end
        state_nxt = S_META_NB;
      end
      S_META_NB: begin
        meta_we    = 1'b1;
        meta_waddr = nb_r;
        meta_wdata = {ld_r + LW'(1), moved_r};
        state_nxt  = S_DIR;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      gd_r      <= '0;
      biu_r     <= (DW + 1)'(1);
      b0_init_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      gd_r      <= gd_nxt;
      biu_r     <= biu_nxt;
      b0_init_r <= b0_init_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    op_r    <= op_nxt;
    b_r     <= b_nxt;
    nb_r    <= nb_nxt;
    ld_r    <= ld_nxt;
    fill_r  <= fill_nxt;
    di_r    <= di_nxt;
    pidx_r  <= pidx_nxt;
    sl_r    <= sl_nxt;
    kept_r  <= kept_nxt;
    moved_r <= moved_nxt;
    res_r   <= res_nxt;
  end

  // Directory entry zero is never re-pointed, so its reads are forced to bucket zero.
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    dir_q     <= dir_mem[dir_raddr];
    dir_rd0_r <= (dir_raddr == '0);
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[kv_waddr] <= kv_wkey;
      val_mem[kv_waddr] <= kv_wval;
    end
    kq <= key_mem[kv_raddr];
    vq <= val_mem[kv_raddr];
  end

endmodule
